// File: sv/iss_pkg.sv
package iss_pkg;

	localparam int unsigned VALUE_W = 32;

	typedef enum logic [0:0] {
		ST_LOAD,
		ST_EMIT
	} state_t;

	// Command broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic                      ins;
		logic                      shift;
		logic signed [VALUE_W-1:0] din;
	} cell_ctrl_t;

endpackage

// File: sv/integer_set_sorter.sv
// Channel   Direction  Handshake             Payload
// s_*       in         s_tvalid / s_tready   s_tdata = value, s_tlast = last
// m_*       out        m_tvalid / m_tready   m_tdata = sorted_value, m_tlast = final_res,
//                                            m_tuser = overflow
//
// Each loaded item is inserted into the sorted chain of cells in the cycle it is
// accepted, by a compare in every cell and a one-place shift.
// After the closing item the set is emptied from the head of the chain, one result per
// cycle while m_tready is high, and s_tready is low while the chain drains. The output
// register lets the next set start loading while the last result still waits. Reset
// empties the chain at once through the per-cell valid flags. A stall on the output
// simply holds the chain in place.
module integer_set_sorter #(
	parameter int unsigned SORT_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [iss_pkg::VALUE_W-1:0]        s_tdata,   // [31:0] value
	input  logic                               s_tlast,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [iss_pkg::VALUE_W-1:0]        m_tdata,   // [31:0] sorted_value
	output logic                               m_tlast,
	output logic                               m_tuser    // [0] overflow
);
	import iss_pkg::*;

	localparam int unsigned CW = $clog2(SORT_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(SORT_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	state_t state_q, state_d;

	logic [CW-1:0]        held_q;
	logic [CW-1:0]        rem_q;
	logic                 drop_q;
	logic                 ovf_q;
	logic                 m_tvalid_q;
	logic [VALUE_W-1:0]   m_tdata_q;
	logic                 m_tlast_q;
	logic                 m_tuser_q;

	logic                 in_acc;
	logic                 full;
	logic                 out_free;
	logic                 pop;
	cell_ctrl_t           ctrl;

	logic [SORT_DEPTH-1:0]      cell_take;
	logic [SORT_DEPTH-1:0]      cell_valid;
	logic signed [VALUE_W-1:0]  cell_value [SORT_DEPTH];

	assign in_acc   = s_tvalid && s_tready;
	assign full     = (held_q == DEPTH_C);
	assign out_free = !m_tvalid_q || m_tready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && s_tlast) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (pop && rem_q == ONE_C) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		s_tready = 1'b0;
		pop      = 1'b0;
		unique case (state_q)
			ST_LOAD: s_tready = 1'b1;
			ST_EMIT: pop      = out_free;
			default: s_tready = 1'b0;
		endcase
	end

	// A value that arrives with the chain full is dropped and marks the set.
	always_comb begin
		ctrl.ins   = in_acc && !full;
		ctrl.shift = pop;
		ctrl.din   = $signed(s_tdata);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			held_q     <= '0;
			rem_q      <= '0;
			drop_q     <= 1'b0;
			ovf_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				if (s_tlast) begin
					rem_q  <= full ? held_q : held_q + ONE_C;
					ovf_q  <= drop_q || full;
					held_q <= '0;
					drop_q <= 1'b0;
				end else begin
					if (!full) begin
						held_q <= held_q + ONE_C;
					end
					drop_q <= drop_q || full;
				end
			end
			if (pop) begin
				rem_q      <= rem_q - ONE_C;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata_q <= cell_value[0];
			m_tlast_q <= (rem_q == ONE_C);
			m_tuser_q <= ovf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	// The chain: cell 0 holds the smallest value. Insertion pushes larger values one
	// place towards the tail; draining pulls every value one place towards the head.
	for (genvar i = 0; i < SORT_DEPTH; i++) begin : g_cell
		logic                      lt;
		logic                      lv;
		logic signed [VALUE_W-1:0] lval;
		logic                      rv;
		logic signed [VALUE_W-1:0] rval;

		if (i == 0) begin : g_head
			assign lt   = 1'b0;
			assign lv   = 1'b0;
			assign lval = '0;
		end else begin : g_mid
			assign lt   = cell_take[i-1];
			assign lv   = cell_valid[i-1];
			assign lval = cell_value[i-1];
		end

		if (i == SORT_DEPTH - 1) begin : g_tail
			assign rv   = 1'b0;
			assign rval = '0;
		end else begin : g_body
			assign rv   = cell_valid[i+1];
			assign rval = cell_value[i+1];
		end

		iss_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.left_take  (lt),
			.left_valid (lv),
			.left_value (lval),
			.right_valid(rv),
			.right_value(rval),
			.take       (cell_take[i]),
			.valid      (cell_valid[i]),
			.value      (cell_value[i])
		);
	end

	a_pop_has_value: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cell_valid[0])
		else $error("drain from an empty chain");

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= DEPTH_C)
		else $error("held count beyond capacity");

	a_fill_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> ($countones(cell_valid) == held_q))
		else $error("occupied cells disagree with held count");

	a_end_of_set: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && rem_q == ONE_C) |=> (state_q == ST_LOAD && cell_valid == '0))
		else $error("chain not empty after final result");

endmodule

// File: sv/iss_cell.sv
module iss_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  iss_pkg::cell_ctrl_t               ctrl,
	input  logic                              left_take,
	input  logic                              left_valid,
	input  logic signed [iss_pkg::VALUE_W-1:0] left_value,
	input  logic                              right_valid,
	input  logic signed [iss_pkg::VALUE_W-1:0] right_value,
	output logic                              take,
	output logic                              valid,
	output logic signed [iss_pkg::VALUE_W-1:0] value
);
	import iss_pkg::*;

	logic                      valid_q;
	logic signed [VALUE_W-1:0] value_q;

	// The incoming value belongs here if this cell is empty or holds a larger value.
	assign take  = !valid_q || (ctrl.din < value_q);
	assign valid = valid_q;
	assign value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins && take) begin
			valid_q <= left_take ? left_valid : 1'b1;
		end else if (ctrl.shift) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && take) begin
			value_q <= left_take ? left_value : ctrl.din;
		end else if (ctrl.shift) begin
			value_q <= right_value;
		end
	end

endmodule
